// File: sv/hsg_pkg.sv
package hsg_pkg;

  localparam int EL_W = 48;
  localparam int NEL = 9;
  localparam int TD_W = EL_W * NEL;
  localparam int DIF_W = EL_W + 1;
  localparam int XW = 52;
  localparam int ZW = 20;
  localparam int ACC_W = 100;
  localparam int CNT_W = 6;
  localparam int CORDIC_STEPS_DEF = 18;
  localparam int MAC_LAST = 8;
  localparam int EL_LAST = NEL - 1;

  localparam logic signed [ZW-1:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [ZW-1:0] PI_Q16 = 20'sd205887;
  localparam logic signed [ZW+1:0] TWO_PI_Q16 = 22'sd411775;
  localparam logic [EL_W-1:0] ONE_Q32 = 48'h0001_0000_0000;
  localparam logic [16:0] ALPHA_ONE = 17'd65536;

  localparam logic [31:0] MAX_TRANS_RST = 32'd983040;
  localparam logic [17:0] MAX_ROT_RST = 18'd1311;
  localparam logic [16:0] ALPHA_RST = 17'd1966;
  localparam logic [3:0] FALLBACK_RST = 4'd3;
  localparam logic [3:0] COUNT_MAX = 4'd15;

  typedef enum logic [1:0] {
    REG_MAX_TRANS = 2'd0,
    REG_MAX_ROT   = 2'd1,
    REG_ALPHA     = 2'd2,
    REG_FALLBACK  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    OUT_HELD   = 3'd0,
    OUT_FIRST  = 3'd1,
    OUT_SMOOTH = 3'd2,
    OUT_REJECT = 3'd3,
    OUT_FORCED = 3'd4
  } outcome_t;

  typedef struct packed {
    logic [31:0] max_translation;
    logic [17:0] max_rotation;
    logic [16:0] blend_alpha;
    logic [3:0]  fallback_limit;
  } cfg_t;

  typedef struct packed {
    logic             capture;
    logic             prep;
    logic             mac_step;
    logic             cordic_init;
    logic             cordic_step;
    logic             angle_save;
    logic             sel;
    logic             blend_mul;
    logic             blend_wr;
    logic             store_new;
    logic             emit;
    logic [CNT_W-1:0] idx;
    outcome_t         outcome;
  } cmd_t;

  typedef struct packed {
    logic present;
    logic held_valid;
    logic trans_ok;
    logic rot_ok;
    logic out_free;
  } sts_t;

  function automatic logic [16:0] atan_q16(input logic [4:0] i);
    logic [16:0] r;
    case (i)
      5'd0:    r = 17'd51472;
      5'd1:    r = 17'd30386;
      5'd2:    r = 17'd16055;
      5'd3:    r = 17'd8150;
      5'd4:    r = 17'd4091;
      5'd5:    r = 17'd2047;
      5'd6:    r = 17'd1024;
      5'd7:    r = 17'd512;
      5'd8:    r = 17'd256;
      5'd9:    r = 17'd128;
      5'd10:   r = 17'd64;
      5'd11:   r = 17'd32;
      5'd12:   r = 17'd16;
      5'd13:   r = 17'd8;
      5'd14:   r = 17'd4;
      5'd15:   r = 17'd2;
      5'd16:   r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/hsg_regs.sv
module hsg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output hsg_pkg::cfg_t       cfg
);

  logic wr;
  hsg_pkg::reg_idx_t ridx;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign ridx = hsg_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_translation <= hsg_pkg::MAX_TRANS_RST;
      cfg.max_rotation <= hsg_pkg::MAX_ROT_RST;
      cfg.blend_alpha <= hsg_pkg::ALPHA_RST;
      cfg.fallback_limit <= hsg_pkg::FALLBACK_RST;
    end else if (wr) begin
      case (ridx)
        hsg_pkg::REG_MAX_TRANS: cfg.max_translation <= pwdata;
        hsg_pkg::REG_MAX_ROT:   cfg.max_rotation <= pwdata[17:0];
        hsg_pkg::REG_ALPHA:     cfg.blend_alpha <= pwdata[16:0];
        hsg_pkg::REG_FALLBACK:  cfg.fallback_limit <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      hsg_pkg::REG_MAX_TRANS: prdata = cfg.max_translation;
      hsg_pkg::REG_MAX_ROT:   prdata = {14'd0, cfg.max_rotation};
      hsg_pkg::REG_ALPHA:     prdata = {15'd0, cfg.blend_alpha};
      hsg_pkg::REG_FALLBACK:  prdata = {28'd0, cfg.fallback_limit};
      default:                prdata = 32'd0;
    endcase
  end

endmodule

// File: sv/hsg_ctrl.sv
module hsg_ctrl #(
  parameter int CORDIC_STEPS = hsg_pkg::CORDIC_STEPS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [3:0]    fallback_limit,
  input  hsg_pkg::sts_t sts,
  output hsg_pkg::cmd_t cmd
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_CHECK  = 12'b000000000010,
    S_TRANS  = 12'b000000000100,
    S_TFLUSH = 12'b000000001000,
    S_TCHK   = 12'b000000010000,
    S_AINIT  = 12'b000000100000,
    S_ARUN   = 12'b000001000000,
    S_ASAVE  = 12'b000010000000,
    S_RCHK   = 12'b000100000000,
    S_BMUL   = 12'b001000000000,
    S_BADD   = 12'b010000000000,
    S_EMIT   = 12'b100000000000
  } state_t;

  localparam logic [hsg_pkg::CNT_W-1:0] STEP_LAST = hsg_pkg::CNT_W'(CORDIC_STEPS - 1);
  localparam logic [hsg_pkg::CNT_W-1:0] MAC_END = hsg_pkg::CNT_W'(hsg_pkg::MAC_LAST);
  localparam logic [hsg_pkg::CNT_W-1:0] EL_END = hsg_pkg::CNT_W'(hsg_pkg::EL_LAST);

  state_t state, state_next;
  logic [hsg_pkg::CNT_W-1:0] cnt, cnt_next;
  logic ang_sel, ang_sel_next;
  logic [3:0] rcount, rcount_next;
  hsg_pkg::outcome_t outcome, outcome_next;
  logic [3:0] rc_inc;

  assign rc_inc = (rcount == hsg_pkg::COUNT_MAX) ? hsg_pkg::COUNT_MAX : rcount + 4'd1;
  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      ang_sel <= 1'b0;
      rcount <= 4'd0;
      outcome <= hsg_pkg::OUT_HELD;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      ang_sel <= ang_sel_next;
      rcount <= rcount_next;
      outcome <= outcome_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    ang_sel_next = ang_sel;
    rcount_next = rcount;
    outcome_next = outcome;
    cmd = '0;
    cmd.idx = cnt;
    cmd.sel = ang_sel;
    cmd.outcome = outcome;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.prep = 1'b1;
        cnt_next = '0;
        if (!sts.present) begin
          outcome_next = hsg_pkg::OUT_HELD;
          state_next = S_EMIT;
        end else if (!sts.held_valid) begin
          cmd.store_new = 1'b1;
          rcount_next = 4'd0;
          outcome_next = hsg_pkg::OUT_FIRST;
          state_next = S_EMIT;
        end else begin
          state_next = S_TRANS;
        end
      end
      S_TRANS: begin
        cmd.mac_step = 1'b1;
        if (cnt == MAC_END) begin
          cnt_next = '0;
          state_next = S_TFLUSH;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_TFLUSH: state_next = S_TCHK;
      S_TCHK, S_RCHK: begin
        if ((state == S_TCHK) ? sts.trans_ok : sts.rot_ok) begin
          cnt_next = '0;
          ang_sel_next = 1'b0;
          state_next = (state == S_TCHK) ? S_AINIT : S_BMUL;
        end else begin
          // gated out: count the run, force the matrix in at the limit
          state_next = S_EMIT;
          if (rc_inc >= fallback_limit) begin
            cmd.store_new = 1'b1;
            rcount_next = 4'd0;
            outcome_next = hsg_pkg::OUT_FORCED;
          end else begin
            rcount_next = rc_inc;
            outcome_next = hsg_pkg::OUT_REJECT;
          end
        end
      end
      S_AINIT: begin
        cmd.cordic_init = 1'b1;
        cnt_next = '0;
        state_next = S_ARUN;
      end
      S_ARUN: begin
        cmd.cordic_step = 1'b1;
        if (cnt == STEP_LAST) begin
          cnt_next = '0;
          state_next = S_ASAVE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_ASAVE: begin
        cmd.angle_save = 1'b1;
        if (!ang_sel) begin
          ang_sel_next = 1'b1;
          state_next = S_AINIT;
        end else begin
          state_next = S_RCHK;
        end
      end
      S_BMUL: begin
        cmd.blend_mul = 1'b1;
        state_next = S_BADD;
      end
      S_BADD: begin
        cmd.blend_wr = 1'b1;
        if (cnt == EL_END) begin
          cnt_next = '0;
          rcount_next = 4'd0;
          outcome_next = hsg_pkg::OUT_SMOOTH;
          state_next = S_EMIT;
        end else begin
          cnt_next = cnt + 1'b1;
          state_next = S_BMUL;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: sv/hsg_dp.sv
module hsg_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [hsg_pkg::TD_W-1:0]  s_tdata,
  input  logic                      s_tuser,
  input  hsg_pkg::cfg_t             cfg,
  input  hsg_pkg::cmd_t             cmd,
  output hsg_pkg::sts_t             sts,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [hsg_pkg::TD_W-1:0]  m_tdata,
  output logic [3:0]                m_tuser
);

  localparam int EW = hsg_pkg::EL_W;
  localparam int DW = hsg_pkg::DIF_W;
  localparam int XW = hsg_pkg::XW;
  localparam int ZW = hsg_pkg::ZW;
  localparam int AW = hsg_pkg::ACC_W;

  logic signed [EW-1:0] m_new [hsg_pkg::NEL];
  logic signed [EW-1:0] held [hsg_pkg::NEL];
  logic present_r, held_valid;

  // translation gate: sum of squares minus threshold squared, 25x25 products
  logic [DW-1:0] ax_r, ay_r, thr, mac_v;
  logic signed [DW-1:0] dx, dy;
  logic [1:0] part;
  logic [24:0] mul_a, mul_b;
  logic [49:0] prod_r;
  logic [6:0] shf_r, shf;
  logic neg_r, pv_r, neg;
  logic signed [AW-1:0] acc;
  logic [AW-1:0] term;

  // cordic
  logic signed [XW-1:0] cx, cy, x0, y0, xs, ys;
  logic signed [ZW-1:0] cz, z0;
  logic czero;
  logic signed [ZW-1:0] ang [2];
  logic signed [ZW-1:0] atan_s;
  logic signed [ZW:0] ad;
  logic signed [ZW:0] adiff;
  logic signed [ZW+1:0] wrapped;

  // blend
  logic [3:0] el;
  logic [16:0] alpha;
  logic signed [DW-1:0] bd;
  logic signed [50:0] p1;
  logic [32:0] p2;
  logic [33:0] p2r;
  logic signed [52:0] bsum;

  assign el = cmd.idx[3:0];
  assign thr = {1'b0, cfg.max_translation, 16'd0};
  assign dx = {m_new[2][EW-1], m_new[2]} - {held[2][EW-1], held[2]};
  assign dy = {m_new[5][EW-1], m_new[5]} - {held[5][EW-1], held[5]};

  always_comb begin
    case (cmd.idx) inside
      [6'd0:6'd2]: mac_v = ax_r;
      [6'd3:6'd5]: mac_v = ay_r;
      default:     mac_v = thr;
    endcase
    case (cmd.idx)
      6'd0, 6'd3, 6'd6: part = 2'd0;
      6'd1, 6'd4, 6'd7: part = 2'd1;
      default:          part = 2'd2;
    endcase
    neg = (cmd.idx >= 6'd6);
    case (part)
      2'd0:    begin mul_a = mac_v[24:0]; mul_b = mac_v[24:0]; shf = 7'd0; end
      2'd1:    begin mul_a = mac_v[24:0]; mul_b = {1'b0, mac_v[48:25]}; shf = 7'd26; end
      default: begin mul_a = {1'b0, mac_v[48:25]}; mul_b = {1'b0, mac_v[48:25]}; shf = 7'd50; end
    endcase
  end

  assign term = {{(AW-50){1'b0}}, prod_r} << shf_r;

  // cordic start point with the quadrant pre-rotation
  always_comb begin
    x0 = cmd.sel ? XW'(m_new[0]) : XW'(held[0]);
    y0 = cmd.sel ? XW'(m_new[3]) : XW'(held[3]);
    x0 = cmd.sel ? {{(XW-EW){m_new[0][EW-1]}}, m_new[0]} : {{(XW-EW){held[0][EW-1]}}, held[0]};
    y0 = cmd.sel ? {{(XW-EW){m_new[3][EW-1]}}, m_new[3]} : {{(XW-EW){held[3][EW-1]}}, held[3]};
    z0 = '0;
    if (x0 < 0) begin
      if (y0 >= 0) begin
        z0 = hsg_pkg::HALF_PI_Q16;
        {x0, y0} = {y0, -x0};
      end else begin
        z0 = -hsg_pkg::HALF_PI_Q16;
        {x0, y0} = {-y0, x0};
      end
    end
  end

  assign xs = cx >>> cmd.idx[4:0];
  assign ys = cy >>> cmd.idx[4:0];
  assign atan_s = $signed({3'd0, hsg_pkg::atan_q16(cmd.idx[4:0])});

  // wrapped angle difference
  always_comb begin
    adiff = {ang[0][ZW-1], ang[0]} - {ang[1][ZW-1], ang[1]};
    ad = adiff[ZW] ? -adiff : adiff;
    wrapped = {ad[ZW], ad};
    if (ad > {hsg_pkg::PI_Q16[ZW-1], hsg_pkg::PI_Q16}) begin
      wrapped = hsg_pkg::TWO_PI_Q16 - {ad[ZW], ad};
      if (wrapped < 0) wrapped = '0;
    end
  end

  assign alpha = (cfg.blend_alpha > hsg_pkg::ALPHA_ONE) ? hsg_pkg::ALPHA_ONE : cfg.blend_alpha;
  assign bd = {m_new[el][EW-1], m_new[el]} - {held[el][EW-1], held[el]};
  assign p2r = {1'b0, p2} + 34'd32768;
  assign bsum = {{5{held[el][EW-1]}}, held[el]} + {{2{p1[50]}}, p1} + {35'd0, p2r[33:16]};

  assign sts.present = present_r;
  assign sts.held_valid = held_valid;
  assign sts.trans_ok = acc[AW-1] || (acc == '0);
  assign sts.rot_ok = (wrapped <= $signed({4'd0, cfg.max_rotation}));
  assign sts.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      pv_r <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.store_new) held_valid <= 1'b1;
      pv_r <= cmd.mac_step;
      if (cmd.emit) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      present_r <= s_tuser;
      for (int k = 0; k < hsg_pkg::NEL; k++) m_new[k] <= s_tdata[k*EW +: EW];
    end
    if (cmd.store_new) begin
      for (int k = 0; k < hsg_pkg::NEL; k++) held[k] <= m_new[k];
    end
    if (cmd.prep) begin
      ax_r <= dx[DW-1] ? DW'(-dx) : DW'(dx);
      ay_r <= dy[DW-1] ? DW'(-dy) : DW'(dy);
      acc <= '0;
    end else if (pv_r) begin
      acc <= neg_r ? acc - $signed(term) : acc + $signed(term);
    end
    if (cmd.mac_step) begin
      prod_r <= mul_a * mul_b;
      shf_r <= shf;
      neg_r <= neg;
    end
    if (cmd.cordic_init) begin
      cx <= x0;
      cy <= y0;
      cz <= z0;
      czero <= (cmd.sel ? (m_new[0] == '0 && m_new[3] == '0)
                        : (held[0] == '0 && held[3] == '0));
    end else if (cmd.cordic_step) begin
      if (cy >= 0) begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + atan_s;
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - atan_s;
      end
    end
    if (cmd.angle_save) ang[cmd.sel] <= czero ? '0 : cz;
    if (cmd.blend_mul) begin
      p1 <= $signed({1'b0, alpha}) * $signed(bd[DW-1:16]);
      p2 <= alpha * bd[15:0];
    end
    if (cmd.blend_wr) held[el] <= bsum[EW-1:0];
    if (cmd.emit) begin
      for (int k = 0; k < hsg_pkg::NEL; k++) begin
        if (held_valid) m_tdata[k*EW +: EW] <= held[k];
        else m_tdata[k*EW +: EW] <= (k % 4 == 0) ? hsg_pkg::ONE_Q32 : '0;
      end
      m_tuser <= {cmd.outcome, held_valid};
    end
  end

endmodule

// File: sv/homography_smoothing_gate_top.sv
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata h00..h22, tuser present
// m_*       out  m_tvalid/m_tready  tdata o00..o22, tuser have_matrix, outcome
// apb       in   psel/penable       max_translation, max_rotation, blend_alpha, fallback_limit
//
// one matrix at a time: a smoothed item passes through the nine-step translation
// multiply-accumulate, two cordic runs on one shared unit and a multiply and a
// write per blended element; a rejection at the translation gate ends after the
// multiply-accumulate, and a hold or first accept goes straight to the output.
// reset is synchronous; it clears control, the held flag and the registers.
// a result waits in the output register while the sink stalls; s_tready drops
// from acceptance until that result is loaded.
module homography_smoothing_gate_top #(
  parameter int CORDIC_STEPS = hsg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [hsg_pkg::TD_W-1:0]  s_tdata,  // h00, h01, h02, h10, h11, h12, h20, h21, h22
  input  logic                      s_tuser,  // present
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [hsg_pkg::TD_W-1:0]  m_tdata,  // o00, o01, o02, o10, o11, o12, o20, o21, o22
  output logic [3:0]                m_tuser,  // have_matrix, outcome[2:0]
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  hsg_pkg::cfg_t cfg;
  hsg_pkg::cmd_t cmd;
  hsg_pkg::sts_t sts;

  hsg_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  hsg_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .fallback_limit(cfg.fallback_limit), .sts(sts), .cmd(cmd)
  );

  hsg_dp u_dp (
    .clk(clk), .rst(rst), .s_tdata(s_tdata), .s_tuser(s_tuser), .cfg(cfg),
    .cmd(cmd), .sts(sts), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

endmodule

// File: sv/hsg_checker.sv
module hsg_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [hsg_pkg::TD_W-1:0]  m_tdata,
  input logic [3:0]                m_tuser
);

  // busy right after taking a transaction
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output dropped while stalled");

  // no matrix held means nothing was gated, and identity goes out
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |->
      m_tuser[3:1] == hsg_pkg::OUT_HELD && m_tdata[47:0] == hsg_pkg::ONE_Q32)
    else $error("empty result not identity");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind homography_smoothing_gate_top hsg_checker u_chk (.*);
